### hw/rtl/gtp_pkg.sv
// ----------------------------------------------------------------------------
// gtp_pkg
// Shared constants, codes and controller/datapath types for the threshold
// propagation engine.
// ----------------------------------------------------------------------------
`default_nettype none

package gtp_pkg;

  localparam int MaxVertices   = 1024;
  localparam int MaxEntries    = 8192;
  localparam int VidW          = $clog2(MaxVertices);
  localparam int CntW          = VidW + 1;
  localparam int EntW          = $clog2(MaxEntries);
  localparam int FillW         = EntW + 1;
  localparam int LenW          = 10;
  localparam int ThrW          = 11;

  localparam logic [LenW-1:0] LenMax = '1;

  localparam logic [2:0] MODE_LOAD   = 3'd0;
  localparam logic [2:0] MODE_APPEND = 3'd1;
  localparam logic [2:0] MODE_SEED   = 3'd2;
  localparam logic [2:0] MODE_RUN    = 3'd3;
  localparam logic [2:0] MODE_QUERY  = 3'd4;

  localparam logic [1:0] ST_UNAWARE  = 2'd0;
  localparam logic [1:0] ST_AWARE    = 2'd1;
  localparam logic [1:0] ST_SPREADER = 2'd2;

  localparam logic KIND_RUN   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLR,
    OP_LOAD,
    OP_APPEND,
    OP_SEED,
    OP_RUN_INIT,
    OP_SCAN_RD,
    OP_SCAN_WR,
    OP_ROUND_START,
    OP_FINISH,
    OP_SPR_RD,
    OP_SPR_ADDR,
    OP_SPR_LATCH,
    OP_NB_RD,
    OP_NB_U,
    OP_NB_UPD
  } cmd_op_t;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_RUN,
    EMIT_QUERY
  } emit_t;

  typedef struct packed {
    cmd_op_t op;
    emit_t   emit;
    logic    query_rd;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic scan_more;
    logic round_go;
    logic spr_more;
    logic nb_more;
    logic u_ok;
    logic can_emit;
  } dp_status_t;

endpackage

`default_nettype wire

### hw/rtl/gtp_datapath.sv
// ----------------------------------------------------------------------------
// gtp_datapath
// Graph stores, frontier queue, run counters and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gtp_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire gtp_pkg::dp_cmd_t             cmd,
  input  wire logic [gtp_pkg::VidW-1:0]     vertex_id,
  input  wire logic [gtp_pkg::VidW-1:0]     neighbor_id,
  input  wire logic [gtp_pkg::ThrW-1:0]     threshold_value,
  input  wire logic                         seed_flag,
  input  wire logic [gtp_pkg::CntW-1:0]     vertex_count,
  output gtp_pkg::dp_status_t               status,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              result_kind,
  output logic [gtp_pkg::CntW-1:0]          aware_count,
  output logic [gtp_pkg::CntW-1:0]          round_count,
  output logic                              all_aware,
  output logic                              store_overflow,
  output logic [1:0]                        vertex_status,
  output logic [gtp_pkg::LenW-1:0]          spreader_neighbors,
  output logic [gtp_pkg::LenW-1:0]          seed_neighbors
);
  import gtp_pkg::*;

  logic [ThrW-1:0] thr_mem   [MaxVertices];
  logic [EntW-1:0] start_mem [MaxVertices];
  logic [LenW-1:0] len_mem   [MaxVertices];
  logic            seed_mem  [MaxVertices];
  logic [1:0]      stat_mem  [MaxVertices];
  logic [LenW-1:0] spc_mem   [MaxVertices];
  logic [LenW-1:0] sdc_mem   [MaxVertices];
  logic [VidW-1:0] nbr_mem   [MaxEntries];
  logic [VidW-1:0] fq_mem    [MaxVertices];

  logic [ThrW-1:0] thr_q;
  logic [EntW-1:0] start_q;
  logic [LenW-1:0] len_q;
  logic            seed_q;
  logic [1:0]      stat_q;
  logic [LenW-1:0] spc_q;
  logic [LenW-1:0] sdc_q;
  logic [VidW-1:0] nbr_q;
  logic [VidW-1:0] fq_q;

  logic [CntW-1:0]  cnt_r, head_r, tail_r, end_r, aware_r, rounds_r;
  logic [CntW-1:0]  aware_tot_r, round_tot_r;
  logic [FillW-1:0] fill_r;
  logic             ovf_r;
  logic [VidW-1:0]  last_v_r;
  logic [LenW-1:0]  last_len_r;
  logic             last_valid_r;
  logic [EntW-1:0]  base_r;
  logic [LenW-1:0]  len_r, k_r;
  logic             fseed_r;
  logic [VidW-1:0]  u_r;

  logic [CntW-1:0]  n_w;
  logic [FillW-1:0] idx_w;
  logic             app_ok;
  logic             scan_seed;
  logic [LenW-1:0]  spc_n, sdc_n;
  logic [1:0]       st_a, st_n;
  logic             enq;

  always_comb begin
    if (vertex_count == '0) begin
      n_w = CntW'(1);
    end else if (vertex_count > CntW'(MaxVertices)) begin
      n_w = CntW'(MaxVertices);
    end else begin
      n_w = vertex_count;
    end
  end

  assign idx_w     = FillW'(base_r) + FillW'(k_r);
  assign app_ok    = (fill_r < FillW'(MaxEntries)) && (last_len_r < LenMax);
  assign scan_seed = seed_q && (cnt_r < n_w);

  always_comb begin
    spc_n = (spc_q == LenMax) ? spc_q : spc_q + 1'b1;
    sdc_n = (fseed_r && sdc_q != LenMax) ? sdc_q + 1'b1 : sdc_q;
    st_a  = (stat_q == ST_UNAWARE) ? ST_AWARE : stat_q;
    enq   = (st_a == ST_AWARE) && (ThrW'(spc_n) >= thr_q) &&
            (tail_r < CntW'(MaxVertices));
    st_n  = enq ? ST_SPREADER : st_a;
  end

  assign status.clr_last  = (cnt_r[VidW-1:0] == VidW'(MaxVertices - 1));
  assign status.scan_more = (cnt_r < CntW'(MaxVertices));
  assign status.round_go  = (aware_r < n_w) && (head_r < tail_r);
  assign status.spr_more  = (head_r < end_r);
  assign status.nb_more   = (k_r < len_r) && (idx_w < FillW'(MaxEntries));
  assign status.u_ok      = (CntW'(nbr_q) < n_w);
  assign status.can_emit  = !out_valid || out_ready;

  // vertex records
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      thr_mem[vertex_id]   <= threshold_value;
      start_mem[vertex_id] <= (vertex_id == '0) ? '0 : fill_r[EntW-1:0];
    end
    if (cmd.op == OP_NB_U) begin
      thr_q <= thr_mem[nbr_q];
    end
    if (cmd.op == OP_SPR_ADDR) begin
      start_q <= start_mem[fq_q];
      len_q   <= len_mem[fq_q];
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_CLR:  len_mem[cnt_r[VidW-1:0]] <= '0;
      OP_LOAD: len_mem[vertex_id]       <= '0;
      OP_APPEND: begin
        if (last_valid_r && app_ok) begin
          len_mem[last_v_r] <= last_len_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_CLR:  seed_mem[cnt_r[VidW-1:0]] <= 1'b0;
      OP_SEED: seed_mem[vertex_id]       <= seed_flag;
      default: ;
    endcase
    if (cmd.op == OP_SCAN_RD) begin
      seed_q <= seed_mem[cnt_r[VidW-1:0]];
    end else if (cmd.op == OP_SPR_ADDR) begin
      seed_q <= seed_mem[fq_q];
    end
  end

  // vertex status and counts
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_CLR: begin
        stat_mem[cnt_r[VidW-1:0]] <= ST_UNAWARE;
        spc_mem[cnt_r[VidW-1:0]]  <= '0;
        sdc_mem[cnt_r[VidW-1:0]]  <= '0;
      end
      OP_SCAN_WR: begin
        stat_mem[cnt_r[VidW-1:0]] <= scan_seed ? ST_SPREADER : ST_UNAWARE;
        spc_mem[cnt_r[VidW-1:0]]  <= '0;
        sdc_mem[cnt_r[VidW-1:0]]  <= '0;
      end
      OP_NB_UPD: begin
        stat_mem[u_r] <= st_n;
        spc_mem[u_r]  <= spc_n;
        sdc_mem[u_r]  <= sdc_n;
      end
      default: ;
    endcase
    if (cmd.op == OP_NB_U) begin
      stat_q <= stat_mem[nbr_q];
      spc_q  <= spc_mem[nbr_q];
      sdc_q  <= sdc_mem[nbr_q];
    end else if (cmd.query_rd) begin
      stat_q <= stat_mem[vertex_id];
      spc_q  <= spc_mem[vertex_id];
      sdc_q  <= sdc_mem[vertex_id];
    end
  end

  // neighbor store
  always_ff @(posedge clk) begin
    if (cmd.op == OP_APPEND && last_valid_r && app_ok) begin
      nbr_mem[fill_r[EntW-1:0]] <= neighbor_id;
    end
    if (cmd.op == OP_NB_RD) begin
      nbr_q <= nbr_mem[idx_w[EntW-1:0]];
    end
  end

  // frontier queue
  always_ff @(posedge clk) begin
    if (cmd.op == OP_SCAN_WR && scan_seed) begin
      fq_mem[tail_r[VidW-1:0]] <= cnt_r[VidW-1:0];
    end else if (cmd.op == OP_NB_UPD && enq) begin
      fq_mem[tail_r[VidW-1:0]] <= u_r;
    end
    if (cmd.op == OP_SPR_RD) begin
      fq_q <= fq_mem[head_r[VidW-1:0]];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      end_r        <= '0;
      aware_r      <= '0;
      rounds_r     <= '0;
      aware_tot_r  <= '0;
      round_tot_r  <= '0;
      fill_r       <= '0;
      ovf_r        <= 1'b0;
      last_v_r     <= '0;
      last_len_r   <= '0;
      last_valid_r <= 1'b0;
      k_r          <= '0;
      len_r        <= '0;
    end else begin
      unique case (cmd.op)
        OP_CLR: cnt_r <= cnt_r + 1'b1;
        OP_LOAD: begin
          if (vertex_id == '0) begin
            fill_r <= '0;
            ovf_r  <= 1'b0;
          end
          last_v_r     <= vertex_id;
          last_len_r   <= '0;
          last_valid_r <= 1'b1;
        end
        OP_APPEND: begin
          if (last_valid_r) begin
            if (app_ok) begin
              fill_r     <= fill_r + 1'b1;
              last_len_r <= last_len_r + 1'b1;
            end else begin
              ovf_r <= 1'b1;
            end
          end
        end
        OP_RUN_INIT: begin
          cnt_r    <= '0;
          head_r   <= '0;
          tail_r   <= '0;
          aware_r  <= '0;
          rounds_r <= '0;
        end
        OP_SCAN_WR: begin
          cnt_r <= cnt_r + 1'b1;
          if (scan_seed) begin
            tail_r  <= tail_r + 1'b1;
            aware_r <= aware_r + 1'b1;
          end
        end
        OP_ROUND_START: begin
          rounds_r <= rounds_r + 1'b1;
          end_r    <= tail_r;
        end
        OP_FINISH: begin
          aware_tot_r <= aware_r;
          round_tot_r <= rounds_r;
        end
        OP_SPR_RD: head_r <= head_r + 1'b1;
        OP_SPR_LATCH: begin
          k_r   <= '0;
          len_r <= len_q;
        end
        OP_NB_U: k_r <= k_r + 1'b1;
        OP_NB_UPD: begin
          if (stat_q == ST_UNAWARE) begin
            aware_r <= aware_r + 1'b1;
          end
          if (enq) begin
            tail_r <= tail_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_SPR_LATCH) begin
      base_r  <= start_q;
      fseed_r <= seed_q;
    end
    if (cmd.op == OP_NB_U) begin
      u_r <= nbr_q;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.emit != EMIT_NONE) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit != EMIT_NONE) begin
      result_kind    <= (cmd.emit == EMIT_QUERY) ? KIND_QUERY : KIND_RUN;
      aware_count    <= aware_tot_r;
      round_count    <= round_tot_r;
      all_aware      <= (aware_tot_r == n_w);
      store_overflow <= ovf_r;
      if (cmd.emit == EMIT_QUERY) begin
        vertex_status      <= stat_q;
        spreader_neighbors <= spc_q;
        seed_neighbors     <= sdc_q;
      end else begin
        vertex_status      <= ST_UNAWARE;
        spreader_neighbors <= '0;
        seed_neighbors     <= '0;
      end
    end
  end

  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= tail_r) else $error("frontier head passed tail");
  a_aware_bound: assert property (@(posedge clk) disable iff (!rst_n)
    aware_r <= CntW'(MaxVertices)) else $error("aware count out of range");
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FillW'(MaxEntries)) else $error("fill pointer out of range");

endmodule

`default_nettype wire

### hw/rtl/gtp_ctrl.sv
// ----------------------------------------------------------------------------
// gtp_ctrl
// Sequencer for store clearing, loads, the spread run and queries.
// ----------------------------------------------------------------------------
`default_nettype none

module gtp_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [2:0]          mode,
  input  wire gtp_pkg::dp_status_t status,
  output gtp_pkg::dp_cmd_t         cmd
);
  import gtp_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_SCAN_RD, S_SCAN_WR, S_ROUND, S_SPR, S_SPR2, S_SPR3,
    S_NB, S_NB_U, S_NB_UPD, S_EMIT_RUN, S_EMIT_Q
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd.op       = OP_NOP;
    cmd.emit     = EMIT_NONE;
    cmd.query_rd = 1'b0;
    unique case (state_r)
      S_CLR: begin
        cmd.op = OP_CLR;
        if (status.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          case (mode)
            MODE_LOAD:   cmd.op = OP_LOAD;
            MODE_APPEND: cmd.op = OP_APPEND;
            MODE_SEED:   cmd.op = OP_SEED;
            MODE_RUN: begin
              cmd.op    = OP_RUN_INIT;
              state_nxt = S_SCAN_RD;
            end
            MODE_QUERY: begin
              cmd.query_rd = 1'b1;
              state_nxt    = S_EMIT_Q;
            end
            default: ;
          endcase
        end
      end
      S_SCAN_RD: begin
        if (status.scan_more) begin
          cmd.op    = OP_SCAN_RD;
          state_nxt = S_SCAN_WR;
        end else begin
          state_nxt = S_ROUND;
        end
      end
      S_SCAN_WR: begin
        cmd.op    = OP_SCAN_WR;
        state_nxt = S_SCAN_RD;
      end
      S_ROUND: begin
        if (status.round_go) begin
          cmd.op    = OP_ROUND_START;
          state_nxt = S_SPR;
        end else begin
          cmd.op    = OP_FINISH;
          state_nxt = S_EMIT_RUN;
        end
      end
      S_SPR: begin
        if (status.spr_more) begin
          cmd.op    = OP_SPR_RD;
          state_nxt = S_SPR2;
        end else begin
          state_nxt = S_ROUND;
        end
      end
      S_SPR2: begin
        cmd.op    = OP_SPR_ADDR;
        state_nxt = S_SPR3;
      end
      S_SPR3: begin
        cmd.op    = OP_SPR_LATCH;
        state_nxt = S_NB;
      end
      S_NB: begin
        if (status.nb_more) begin
          cmd.op    = OP_NB_RD;
          state_nxt = S_NB_U;
        end else begin
          state_nxt = S_SPR;
        end
      end
      S_NB_U: begin
        cmd.op    = OP_NB_U;
        state_nxt = status.u_ok ? S_NB_UPD : S_NB;
      end
      S_NB_UPD: begin
        cmd.op    = OP_NB_UPD;
        state_nxt = S_NB;
      end
      S_EMIT_RUN: begin
        if (status.can_emit) begin
          cmd.emit  = EMIT_RUN;
          state_nxt = S_IDLE;
        end
      end
      S_EMIT_Q: begin
        if (status.can_emit) begin
          cmd.emit  = EMIT_QUERY;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/graph_threshold_propagation.sv
// ----------------------------------------------------------------------------
// graph_threshold_propagation
// Threshold spread engine over a loaded graph with APB configuration.
// ----------------------------------------------------------------------------
// Load, append and seed transactions are accepted back to back.
// A query reads the vertex record, then waits in an emit state until the result
// register is free; the next input is taken once it has emitted.
// A run scans every vertex, then walks the frontier round by round before it emits.
// After reset a clearing pass over all 1024 vertex slots runs; no transaction is
// accepted until it ends. Configuration writes are taken at any time.
`default_nettype none

module graph_threshold_propagation (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // vertex_id[9:0], neighbor_id[19:10], threshold_value[30:20], seed_flag[31]
  input  wire logic [31:0] in_tdata,
  // mode[2:0]
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // aware_count[10:0], round_count[21:11], all_aware[22], store_overflow[23],
  // vertex_status[25:24], spreader_neighbors[35:26], seed_neighbors[45:36]
  output logic [47:0]      out_tdata,
  // result_kind[0]
  output logic             out_tuser,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import gtp_pkg::*;

  localparam logic [2:0] ADDR_VERTEX_COUNT = 3'd0;

  logic [CntW-1:0] vcount_r;
  dp_cmd_t         cmd;
  dp_status_t      status;
  logic [CntW-1:0] aware_count, round_count;
  logic            all_aware, store_overflow;
  logic [1:0]      vertex_status;
  logic [LenW-1:0] spreader_neighbors, seed_neighbors;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ADDR_VERTEX_COUNT) ? 32'(vcount_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= CntW'(MaxVertices);
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr == ADDR_VERTEX_COUNT) begin
      vcount_r <= cfg_pwdata[CntW-1:0];
    end
  end

  gtp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .mode     (in_tuser),
    .status   (status),
    .cmd      (cmd)
  );

  gtp_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .vertex_id          (in_tdata[9:0]),
    .neighbor_id        (in_tdata[19:10]),
    .threshold_value    (in_tdata[30:20]),
    .seed_flag          (in_tdata[31]),
    .vertex_count       (vcount_r),
    .status             (status),
    .out_valid          (out_tvalid),
    .out_ready          (out_tready),
    .result_kind        (out_tuser),
    .aware_count        (aware_count),
    .round_count        (round_count),
    .all_aware          (all_aware),
    .store_overflow     (store_overflow),
    .vertex_status      (vertex_status),
    .spreader_neighbors (spreader_neighbors),
    .seed_neighbors     (seed_neighbors)
  );

  assign out_tdata = {2'b00, seed_neighbors, spreader_neighbors, vertex_status,
                      store_overflow, all_aware, round_count, aware_count};

endmodule

`default_nettype wire

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the threshold propagation engine: loads graphs,
// seeds, runs and queries over the input stream, predicts every run summary
// and query answer in a scoreboard, and checks the result stream against it
// under several sender and receiver idle patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import gtp_pkg::*;

  localparam int LIMIT = 400000;
  localparam logic [2:0] REG_VERTEX_COUNT = 3'd0;

  typedef struct packed {
    logic        kind;
    logic [10:0] aware;
    logic [10:0] rounds;
    logic        all_aware;
    logic        ovf;
    logic [1:0]  status;
    logic [9:0]  spr_nb;
    logic [9:0]  seed_nb;
  } answer_t;

  class spread_scoreboard;
    int          vcount_reg;
    int          thresh[1024];
    int          lstart[1024];
    int          llen[1024];
    int          nstore[8192];
    int          fill;
    bit          seed[1024];
    logic [1:0]  status[1024];
    int          scnt[1024];
    int          sdcnt[1024];
    int          aware_tot;
    int          round_tot;
    bit          ovf;
    int          last_v;
    bit          last_ok;
    answer_t     pending_q[$];
    int          mismatches;

    function new();
      vcount_reg = 1024;
      fill = 0;
      aware_tot = 0;
      round_tot = 0;
      ovf = 0;
      last_ok = 0;
      mismatches = 0;
      for (int i = 0; i < 1024; i++) begin
        seed[i] = 0;
        status[i] = ST_UNAWARE;
        scnt[i] = 0;
        sdcnt[i] = 0;
        llen[i] = 0;
      end
    endfunction

    function int used();
      if (vcount_reg == 0) return 1;
      if (vcount_reg > 1024) return 1024;
      return vcount_reg;
    endfunction

    function void spread();
      int n, head, tail, aware, rounds, stop, s, u, idx;
      int frontier[1024];
      n = used();
      head = 0;
      tail = 0;
      aware = 0;
      rounds = 0;
      for (int v = 0; v < 1024; v++) begin
        status[v] = ST_UNAWARE;
        scnt[v] = 0;
        sdcnt[v] = 0;
      end
      for (int v = 0; v < n; v++) begin
        if (seed[v]) begin
          status[v] = ST_SPREADER;
          frontier[tail++] = v;
          aware++;
        end
      end
      while (aware < n && head < tail) begin
        stop = tail;
        rounds++;
        while (head < stop) begin
          s = frontier[head++];
          for (int k = 0; k < llen[s]; k++) begin
            idx = lstart[s] + k;
            if (idx >= 8192) break;
            u = nstore[idx];
            if (u >= n) continue;
            if (scnt[u] < 1023) scnt[u]++;
            if (seed[s] && sdcnt[u] < 1023) sdcnt[u]++;
            if (status[u] == ST_UNAWARE) begin
              status[u] = ST_AWARE;
              aware++;
            end
            if (status[u] == ST_AWARE && scnt[u] >= thresh[u] && tail < 1024) begin
              status[u] = ST_SPREADER;
              frontier[tail++] = u;
            end
          end
        end
      end
      aware_tot = aware > 2047 ? 2047 : aware;
      round_tot = rounds > 2047 ? 2047 : rounds;
    endfunction

    function void note_input(logic [2:0] mode, logic [9:0] vid, logic [9:0] nid,
                             logic [10:0] thr, logic sf);
      answer_t a;
      case (mode)
        MODE_LOAD: begin
          if (vid == 0) begin
            fill = 0;
            ovf = 0;
          end
          thresh[vid] = thr;
          lstart[vid] = fill;
          llen[vid] = 0;
          last_v = vid;
          last_ok = 1;
        end
        MODE_APPEND: begin
          if (last_ok) begin
            if (fill >= 8192 || llen[last_v] >= 1023) begin
              ovf = 1;
            end else begin
              nstore[fill++] = nid;
              llen[last_v]++;
            end
          end
        end
        MODE_SEED: seed[vid] = sf;
        MODE_RUN, MODE_QUERY: begin
          if (mode == MODE_RUN) spread();
          a = '0;
          a.kind = (mode == MODE_QUERY) ? KIND_QUERY : KIND_RUN;
          a.aware = 11'(aware_tot);
          a.rounds = 11'(round_tot);
          a.all_aware = (aware_tot == used());
          a.ovf = ovf;
          if (mode == MODE_QUERY) begin
            a.status = status[vid];
            a.spr_nb = 10'(scnt[vid]);
            a.seed_nb = 10'(sdcnt[vid]);
          end
          pending_q = {pending_q, a};
        end
        default: ;
      endcase
    endfunction

    function void check(logic kind, logic [47:0] d);
      answer_t got, exp_a;
      got = {kind, d[10:0], d[21:11], d[22], d[23], d[25:24], d[35:26], d[45:36]};
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction %p", got);
        return;
      end
      exp_a = pending_q.pop_front();
      if (got.kind !== exp_a.kind || got.aware !== exp_a.aware ||
          got.rounds !== exp_a.rounds || got.all_aware !== exp_a.all_aware ||
          got.ovf !== exp_a.ovf || got.status !== exp_a.status ||
          got.spr_nb !== exp_a.spr_nb || got.seed_nb !== exp_a.seed_nb) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp_a, got);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [47:0] out_tdata;
  logic        out_tuser;
  logic        cfg_psel = 0;
  logic        cfg_penable = 0;
  logic        cfg_pwrite = 0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  spread_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  quiet_cycles = 0;
  int  sent = 0;
  bit  loaded[1024];

  graph_threshold_propagation u_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check(out_tuser, out_tdata);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic bit all_loaded();
    for (int v = 0; v < sb.used(); v++) if (!loaded[v]) return 0;
    return 1;
  endfunction

  task automatic send_item(logic [2:0] mode, logic [9:0] vid, logic [9:0] nid,
                           logic [10:0] thr, logic sf);
    logic [2:0] m;
    m = mode;
    if (m == MODE_RUN && !all_loaded()) m = MODE_QUERY;
    @(negedge clk);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid = 0;
      @(negedge clk);
    end
    in_tvalid = 1;
    in_tuser = m;
    in_tdata = {sf, thr, nid, vid};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(m, vid, nid, thr, sf);
    if (m == MODE_LOAD) loaded[vid] = 1;
    sent++;
  endtask

  task automatic release_input();
    @(negedge clk);
    in_tvalid = 0;
  endtask

  task automatic drain();
    release_input();
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_vertex_count(int value);
    drain();
    @(negedge clk);
    cfg_psel = 1;
    cfg_pwrite = 1;
    cfg_penable = 0;
    cfg_paddr = REG_VERTEX_COUNT;
    cfg_pwdata = value;
    @(negedge clk);
    cfg_penable = 1;
    @(posedge clk);
    sb.vcount_reg = value & 32'h7ff;
    @(negedge clk);
    cfg_psel = 0;
    cfg_penable = 0;
    cfg_pwrite = 0;
  endtask

  task automatic noise_item();
    send_item(3'($urandom_range(5, 7)), 10'($urandom), 10'($urandom),
              11'($urandom_range(0, 1024)), 1'($urandom));
  endtask

  task automatic graph_phase(int vc, int budget);
    int start, nu, nv, deg, thr;
    start = sent;
    write_vertex_count(vc);
    nu = sb.used();
    while (sent - start < budget) begin
      nv = nu + $urandom_range(0, 2);
      if (nv > 1024) nv = 1024;
      for (int v = 0; v < nv; v++) begin
        if ($urandom_range(9) == 0) thr = $urandom_range(0, 1024);
        else thr = (nu > 64) ? $urandom_range(2, 6) : $urandom_range(0, 3);
        send_item(MODE_LOAD, 10'(v), 0, 11'(thr), 0);
        deg = (nu > 64) ? $urandom_range(0, 1) : $urandom_range(0, 4);
        repeat (deg) begin
          send_item(MODE_APPEND, 0,
                    ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(0, nu - 1)),
                    0, 0);
        end
      end
      repeat ($urandom_range(1, 3)) begin
        send_item(MODE_SEED,
                  ($urandom_range(7) == 0) ? 10'($urandom) : 10'($urandom_range(0, nu - 1)),
                  0, 0, ($urandom_range(7) != 0));
      end
      repeat ($urandom_range(0, 2)) begin
        case ($urandom_range(2))
          0: noise_item();
          1: send_item(MODE_APPEND, 0, 10'($urandom), 0, 0);
          default: send_item(MODE_SEED, 10'($urandom), 0, 0, 1'($urandom));
        endcase
      end
      send_item(MODE_RUN, 0, 0, 0, 0);
      repeat ($urandom_range(1, 4)) begin
        send_item(MODE_QUERY,
                  ($urandom_range(5) == 0) ? 10'($urandom) : 10'($urandom_range(0, nu - 1)),
                  0, 0, 0);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    send_item(MODE_APPEND, 0, 10'd5, 0, 0);
    send_item(MODE_QUERY, 10'd1023, 0, 0, 0);
    send_item(MODE_QUERY, 10'd0, 0, 0, 0);
    send_item(3'd5, 10'h3ff, 10'h3ff, 11'h7ff, 1);
    send_item(3'd6, 0, 0, 0, 0);
    send_item(3'd7, 10'h2aa, 10'h155, 11'd1024, 0);
    write_vertex_count(4);
    send_item(MODE_LOAD, 0, 0, 11'd0, 0);
    send_item(MODE_APPEND, 0, 10'd1, 0, 0);
    send_item(MODE_APPEND, 0, 10'd3, 0, 0);
    send_item(MODE_APPEND, 0, 10'd1023, 0, 0);
    send_item(MODE_LOAD, 1, 0, 11'd1, 0);
    send_item(MODE_APPEND, 0, 10'd2, 0, 0);
    send_item(MODE_LOAD, 2, 0, 11'd1024, 0);
    send_item(MODE_APPEND, 0, 10'd0, 0, 0);
    send_item(MODE_LOAD, 3, 0, 11'd2, 0);
    send_item(MODE_APPEND, 0, 10'd2, 0, 0);
    send_item(MODE_LOAD, 2, 0, 11'd1, 0);
    send_item(MODE_SEED, 0, 0, 0, 1);
    send_item(MODE_SEED, 10'd1023, 0, 0, 1);
    send_item(MODE_SEED, 10'd1023, 0, 0, 0);
    send_item(MODE_RUN, 0, 0, 0, 0);
    for (int v = 0; v < 4; v++) send_item(MODE_QUERY, 10'(v), 0, 0, 0);

    // fill one list past its limit, with a hot vertex
    write_vertex_count(16);
    for (int v = 0; v < 2; v++) begin
      send_item(MODE_LOAD, 10'(v), 0, 11'($urandom_range(0, 3)), 0);
      repeat (v == 0 ? 1024 : 10) send_item(MODE_APPEND, 0, 10'd2, 0, 0);
    end
    for (int v = 2; v < 16; v++) begin
      send_item(MODE_LOAD, 10'(v), 0, 11'($urandom_range(0, 3)), 0);
      repeat (2) send_item(MODE_APPEND, 0, 10'($urandom_range(0, 20)), 0, 0);
    end
    send_item(MODE_SEED, 0, 0, 0, 1);
    send_item(MODE_SEED, 1, 0, 0, 1);
    send_item(MODE_RUN, 0, 0, 0, 0);
    for (int v = 0; v < 16; v++) send_item(MODE_QUERY, 10'(v), 0, 0, 0);
    send_item(MODE_LOAD, 0, 0, 11'd1, 0);
    send_item(MODE_QUERY, 10'd2, 0, 0, 0);
    for (int v = 0; v < 16; v++) send_item(MODE_SEED, 10'(v), 0, 0, 0);

    write_vertex_count(2047);
    send_item(MODE_RUN, 0, 0, 0, 0);
    repeat (8) send_item(MODE_QUERY, 10'($urandom), 0, 0, 0);
    graph_phase(0, 30);
    graph_phase(1, 30);

    for (int p = 0; p < 4; p++) begin
      drain();
      send_idle_pct = (p == 1) ? 74 : (p == 3) ? 6 : 0;
      recv_stall_pct = (p == 2) ? 74 : (p == 3) ? 6 : 0;
      graph_phase(8, 30);
      graph_phase(32, 20);
      graph_phase(3, 20);
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### graph_threshold_propagation.f
hw/rtl/gtp_pkg.sv
hw/rtl/gtp_datapath.sv
hw/rtl/gtp_ctrl.sv
hw/rtl/graph_threshold_propagation.sv
tb/sv/tb.sv
